// ----- rtl/ctl_pkg.sv -----
// Package for the connection tuple lookup block: item codes, entry and scan types.
// Used by ctl_cell and connection_tuple_lookup; depends on nothing else.
`timescale 1ns / 1ps

package ctl_pkg;

	// Default number of table slots.
	localparam int ENTRIES_DEF = 16;

	// Width of the slot index fields on the ports.
	localparam int SLOT_W = 4;

	// Item function codes.
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// Result kind codes.
	localparam logic KIND_EXACT  = 1'b0;
	localparam logic KIND_LISTEN = 1'b1;

	// Flag value of an entry in the listen state.
	localparam logic ENTRY_LISTENING = 1'b1;

	// The four-tuple of a connection.
	typedef struct packed {
		logic [31:0] local_addr;
		logic [15:0] local_port_no;
		logic [31:0] remote_addr;
		logic [15:0] remote_port_no;
	} tuple_t;

	// Running result of a lookup as it moves down the chain.
	typedef struct packed {
		logic              exact;
		logic [SLOT_W-1:0] exact_slot;
		logic              listen;
		logic [SLOT_W-1:0] listen_slot;
	} scan_t;

endpackage

// ----- rtl/ctl_cell.sv -----
// One cell of the lookup chain: holds one table slot and updates the passing scan.
// Depends on ctl_pkg.
`timescale 1ns / 1ps

module ctl_cell
	import ctl_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_slot,
	input  tuple_t            wr_tuple,
	input  logic              wr_listening,
	input  logic              wr_valid,
	input  tuple_t            key,
	input  scan_t             scan_in,
	input  logic              step_in,
	output scan_t             scan_out,
	output logic              step_out
);

	tuple_t entry_q;
	logic   listening_q;
	logic   valid_q;
	logic   sel;
	logic   match_exact;
	logic   match_listen;
	scan_t  scan_nx;
	scan_t  scan_s1;
	logic   step_s1;

	// A write lands here only when the slot index names this cell.
	assign sel = wr_en && (32'(wr_slot) == IDX);

	// Stored entry; the valid flag alone is cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			valid_q <= wr_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			entry_q     <= wr_tuple;
			listening_q <= wr_listening;
		end
	end

	// Compare this slot against the key of the lookup.
	assign match_exact = valid_q && (entry_q == key);
	assign match_listen = valid_q && (listening_q == ENTRY_LISTENING) &&
		(entry_q.local_port_no == key.local_port_no) &&
		((entry_q.local_addr == 32'd0) || (entry_q.local_addr == key.local_addr));

	// The first exact match is kept; a later listening match replaces an earlier one.
	always_comb begin
		scan_nx = scan_in;
		if (!scan_in.exact) begin
			if (match_exact) begin
				scan_nx.exact      = 1'b1;
				scan_nx.exact_slot = SLOT_W'(IDX);
			end else if (match_listen) begin
				scan_nx.listen      = 1'b1;
				scan_nx.listen_slot = SLOT_W'(IDX);
			end
		end
	end

	// Hand the scan to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= step_in;
		end
	end

	always_ff @(posedge clk) begin
		if (step_in) begin
			scan_s1 <= scan_nx;
		end
	end

	assign scan_out = scan_s1;
	assign step_out = step_s1;

endmodule

// ----- rtl/connection_tuple_lookup.sv -----
// Top level of the connection tuple lookup: command port, key register and cell chain.
// Depends on ctl_pkg and ctl_cell.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low. A write (func = 0) updates
// its slot at that edge and its all-zero result shows on done in the next cycle;
// busy stays low, so a new item may follow at once. A lookup (func = 1) walks a
// chain of ENTRIES cells, one cell per cycle, and its result shows on done when it
// leaves the last cell; busy is high from its acceptance until that result, so no
// new item is taken while a lookup is in the chain. Each result is on the ports for
// exactly one cycle with done high and cannot be held off. Only the valid flags are
// cleared by reset; no clearing pass is needed.
module connection_tuple_lookup
	import ctl_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [SLOT_W-1:0] slot,
	input  logic [31:0]       local_addr,
	input  logic [15:0]       local_port_no,
	input  logic [31:0]       remote_addr,
	input  logic [15:0]       remote_port_no,
	input  logic              listening,
	input  logic              entry_valid,
	output logic              done,
	output logic              hit,
	output logic [SLOT_W-1:0] hit_slot,
	output logic              hit_kind
);

	logic   accept;
	logic   wr_en;
	logic   lookup_go;
	logic   busy_q;
	logic   go_q;
	logic   wr_done_q;
	tuple_t key_q;
	tuple_t in_tuple;
	scan_t  scan [ENTRIES+1];
	logic   step [ENTRIES+1];
	logic   last_step;
	scan_t  last_scan;
	logic [ENTRIES-1:0] step_vec;

	assign accept    = start && !busy_q;
	assign wr_en     = accept && (func == FUNC_WRITE);
	assign lookup_go = accept && (func == FUNC_LOOKUP);

	assign in_tuple.local_addr     = local_addr;
	assign in_tuple.local_port_no  = local_port_no;
	assign in_tuple.remote_addr    = remote_addr;
	assign in_tuple.remote_port_no = remote_port_no;

	// Control: busy covers a lookup from its acceptance to its result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			go_q      <= 1'b0;
			wr_done_q <= 1'b0;
		end else begin
			go_q      <= lookup_go;
			wr_done_q <= wr_en;
			if (lookup_go) begin
				busy_q <= 1'b1;
			end else if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The key is held for the whole walk down the chain.
	always_ff @(posedge clk) begin
		if (lookup_go) begin
			key_q <= in_tuple;
		end
	end

	// Inject an empty scan at the head of the chain.
	assign scan[0] = '0;
	assign step[0] = go_q;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ctl_cell #(
			.IDX(i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.wr_en       (wr_en),
			.wr_slot     (slot),
			.wr_tuple    (in_tuple),
			.wr_listening(listening),
			.wr_valid    (entry_valid),
			.key         (key_q),
			.scan_in     (scan[i]),
			.step_in     (step[i]),
			.scan_out    (scan[i+1]),
			.step_out    (step[i+1])
		);
		assign step_vec[i] = step[i+1];
	end

	assign last_step = step[ENTRIES];
	assign last_scan = scan[ENTRIES];

	// Result ports: a write and a lookup result never share a cycle.
	always_comb begin
		done     = wr_done_q || last_step;
		hit      = 1'b0;
		hit_slot = '0;
		hit_kind = KIND_EXACT;
		if (last_step) begin
			if (last_scan.exact) begin
				hit      = 1'b1;
				hit_slot = last_scan.exact_slot;
			end else if (last_scan.listen) begin
				hit      = 1'b1;
				hit_slot = last_scan.listen_slot;
				hit_kind = KIND_LISTEN;
			end
		end
	end

	assign busy = busy_q;

	// At most one lookup walks the chain at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(step_vec))
		else $error("more than one lookup in the cell chain");

	// A lookup result only appears while busy is held.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		last_step |-> busy_q)
		else $error("lookup result without busy");

	// A write result never collides with a lookup result.
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		wr_done_q |-> !last_step)
		else $error("write and lookup results in one cycle");

	// Busy falls only when the lookup result is delivered.
	a_busy_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(last_step))
		else $error("busy dropped before the lookup result");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for connection_tuple_lookup: table writes and tuple lookups.
// Depends on ctl_pkg and the connection_tuple_lookup RTL; reads no files.
`timescale 1ns / 1ps

module tb;
	import ctl_pkg::*;

	// One command item as it is driven onto the ports.
	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot;
		tuple_t            key;
		logic              listening;
		logic              entry_valid;
	} conn_item_t;

	// One result as it shows on the ports.
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              kind;
	} lookup_result_t;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PER_PHASE = 610;

	// Connection table shadow and the queue of results it predicts.
	class lookup_table_tracker;
		tuple_t         slot_key[ENTRIES_DEF];
		logic           slot_listen[ENTRIES_DEF];
		logic           slot_valid[ENTRIES_DEF];
		lookup_result_t pending_results[$];
		int             mismatches;
		int             writes;
		int             exact_hits;
		int             listen_hits;
		int             misses;

		function new();
			foreach (slot_valid[i]) begin
				slot_valid[i] = 1'b0;
				slot_listen[i] = 1'b0;
				slot_key[i] = '0;
			end
			mismatches = 0;
			writes = 0;
			exact_hits = 0;
			listen_hits = 0;
			misses = 0;
		endfunction

		// Scan valid slots in order: the first exact match wins outright,
		// otherwise the last listening slot with a matching local side.
		function lookup_result_t resolve_lookup(tuple_t key);
			lookup_result_t r;
			logic           found_listen;
			int             listen_at;
			r = '0;
			found_listen = 1'b0;
			listen_at = 0;
			for (int i = 0; i < ENTRIES_DEF; i++) begin
				if (!slot_valid[i])
					continue;
				if (slot_key[i] == key) begin
					r.hit = 1'b1;
					r.slot = SLOT_W'(i);
					r.kind = KIND_EXACT;
					return r;
				end
				if (slot_listen[i] == ENTRY_LISTENING &&
						slot_key[i].local_port_no == key.local_port_no &&
						(slot_key[i].local_addr == '0 ||
						slot_key[i].local_addr == key.local_addr)) begin
					found_listen = 1'b1;
					listen_at = i;
				end
			end
			if (found_listen) begin
				r.hit = 1'b1;
				r.slot = SLOT_W'(listen_at);
				r.kind = KIND_LISTEN;
			end
			return r;
		endfunction

		// Note an accepted item: apply a write and queue its all-zero result, or predict a lookup result.
		function void record_item(conn_item_t it);
			lookup_result_t r;
			r = '0;
			if (it.func == FUNC_WRITE) begin
				writes++;
				if (it.slot < ENTRIES_DEF) begin
					slot_key[it.slot] = it.key;
					slot_listen[it.slot] = it.listening;
					slot_valid[it.slot] = it.entry_valid;
				end
			end else begin
				r = resolve_lookup(it.key);
				if (!r.hit)
					misses++;
				else if (r.kind == KIND_EXACT)
					exact_hits++;
				else
					listen_hits++;
			end
			pending_results.push_back(r);
		endfunction

		// Check one result from the block against the oldest prediction.
		function void compare_result(logic hit, logic [SLOT_W-1:0] slot, logic kind);
			lookup_result_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result hit=%0b slot=%0d kind=%0b %s",
						$time, hit, slot, kind, "with no item waiting");
				return;
			end
			want = pending_results.pop_front();
			if (hit !== want.hit || slot !== want.slot || kind !== want.kind) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: expected hit=%0b slot=%0d kind=%0b, %s",
						$time, want.hit, want.slot, want.kind,
						$sformatf("got hit=%0b slot=%0d kind=%0b", hit, slot, kind));
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              func = FUNC_WRITE;
	logic [SLOT_W-1:0] slot = '0;
	logic [31:0]       local_addr = '0;
	logic [15:0]       local_port_no = '0;
	logic [31:0]       remote_addr = '0;
	logic [15:0]       remote_port_no = '0;
	logic              listening = 1'b0;
	logic              entry_valid = 1'b0;
	logic              done;
	logic              hit;
	logic [SLOT_W-1:0] hit_slot;
	logic              hit_kind;

	lookup_table_tracker tracker;
	int                  stall_cycles = 0;
	logic [31:0]         addr_pool[4];
	logic [15:0]         port_pool[4];

	connection_tuple_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.slot(slot),
		.local_addr(local_addr),
		.local_port_no(local_port_no),
		.remote_addr(remote_addr),
		.remote_port_no(remote_port_no),
		.listening(listening),
		.entry_valid(entry_valid),
		.done(done),
		.hit(hit),
		.hit_slot(hit_slot),
		.hit_kind(hit_kind)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Every strobed result is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.compare_result(hit, hit_slot, hit_kind);
	end

	// End the run if neither an item nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no progress for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// Present one item and hold it until the block takes it.
	task automatic send_item(input conn_item_t it);
		start <= 1'b1;
		func <= it.func;
		slot <= it.slot;
		local_addr <= it.key.local_addr;
		local_port_no <= it.key.local_port_no;
		remote_addr <= it.key.remote_addr;
		remote_port_no <= it.key.remote_port_no;
		listening <= it.listening;
		entry_valid <= it.entry_valid;
		do
			@(posedge clk);
		while (busy);
		tracker.record_item(it);
	endtask

	task automatic send_fields(input logic f, input logic [SLOT_W-1:0] s,
			input logic [31:0] la, input logic [15:0] lp,
			input logic [31:0] ra, input logic [15:0] rp,
			input logic lis, input logic val);
		conn_item_t it;
		it.func = f;
		it.slot = s;
		it.key = {la, lp, ra, rp};
		it.listening = lis;
		it.entry_valid = val;
		send_item(it);
	endtask

	// Drop start for a random gap, extended while a draw stays below pct.
	task automatic sender_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Hold off until every predicted result has come back.
	task automatic wait_drained();
		if (tracker.pending_results.size() != 0) begin
			start <= 1'b0;
			while (tracker.pending_results.size() != 0)
				@(posedge clk);
		end
	endtask

	function automatic tuple_t random_tuple();
		tuple_t t;
		t = {$urandom, 16'($urandom), $urandom, 16'($urandom)};
		return t;
	endfunction

	function automatic tuple_t pool_tuple();
		tuple_t t;
		t.local_addr = addr_pool[$urandom_range(3)];
		t.local_port_no = port_pool[$urandom_range(3)];
		t.remote_addr = addr_pool[$urandom_range(3)];
		t.remote_port_no = port_pool[$urandom_range(3)];
		return t;
	endfunction

	// Mostly tuples drawn from small pools or copied from live entries,
	// so that exact and listening hits are frequent.
	function automatic conn_item_t random_item();
		conn_item_t it;
		int         pick;
		int         s;
		it.func = ($urandom_range(99) < 35) ? FUNC_WRITE : FUNC_LOOKUP;
		it.slot = SLOT_W'($urandom);
		it.listening = ($urandom_range(99) < 40);
		it.entry_valid = ($urandom_range(99) < 80);
		it.key = pool_tuple();
		pick = $urandom_range(99);
		s = $urandom_range(ENTRIES_DEF - 1);
		if (it.func == FUNC_WRITE) begin
			if (pick < 15)
				it.key = random_tuple();
			else if (it.listening && pick < 60)
				it.key.local_addr = '0;
		end else if (pick < 45) begin
			if (tracker.slot_valid[s])
				it.key = tracker.slot_key[s];
		end else if (pick < 65) begin
			// Probe the local side of a live entry with a fresh remote side.
			it.key = random_tuple();
			if (tracker.slot_valid[s]) begin
				it.key.local_port_no = tracker.slot_key[s].local_port_no;
				if (tracker.slot_key[s].local_addr != '0)
					it.key.local_addr = tracker.slot_key[s].local_addr;
			end
		end else if (pick < 85) begin
			it.key = random_tuple();
		end
		return it;
	endfunction

	// Directed cases: empty table, exact and listening hits, last listener,
	// freed slots, exact beating a lower listener, duplicates, extremes.
	task automatic directed_items();
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] ar;
		logic [15:0] pp;
		logic [15:0] pq;
		ax = 32'hC0A8_0001;
		ay = 32'h0A00_0002;
		ar = 32'h0808_0808;
		pp = 16'd80;
		pq = 16'd51000;
		send_fields(FUNC_LOOKUP, 4'd15, ax, pp, ar, pq, 1'b1, 1'b1);
		send_fields(FUNC_WRITE, 4'd0, ax, pp, ar, pq, 1'b0, 1'b1);
		send_fields(FUNC_LOOKUP, 4'd0, ax, pp, ar, pq, 1'b0, 1'b0);
		send_fields(FUNC_WRITE, 4'd15, '0, pp, '0, '0, ENTRY_LISTENING, 1'b1);
		send_fields(FUNC_LOOKUP, 4'd7, ay, pp, ar, pq + 16'd1, 1'b0, 1'b1);
		send_fields(FUNC_WRITE, 4'd3, ax, pp, '0, '0, ENTRY_LISTENING, 1'b1);
		send_fields(FUNC_LOOKUP, 4'd0, ax, pp, ar, pq + 16'd1, 1'b1, 1'b0);
		send_fields(FUNC_WRITE, 4'd15, '0, pp, '0, '0, ENTRY_LISTENING, 1'b0);
		send_fields(FUNC_LOOKUP, 4'd0, ax, pp, ar, pq + 16'd1, 1'b0, 1'b0);
		send_fields(FUNC_LOOKUP, 4'd0, ay, pp, ar, pq + 16'd1, 1'b0, 1'b0);
		send_fields(FUNC_WRITE, 4'd9, ax, pp, ar, pq + 16'd2, 1'b0, 1'b1);
		send_fields(FUNC_LOOKUP, 4'd0, ax, pp, ar, pq + 16'd2, 1'b0, 1'b0);
		send_fields(FUNC_WRITE, 4'd5, ax, pp, ar, pq + 16'd2, 1'b0, 1'b1);
		send_fields(FUNC_LOOKUP, 4'd0, ax, pp, ar, pq + 16'd2, 1'b0, 1'b0);
		send_fields(FUNC_WRITE, 4'd14, '1, '1, '1, '1, ENTRY_LISTENING, 1'b1);
		send_fields(FUNC_LOOKUP, 4'd0, '1, '1, '1, '1, 1'b0, 1'b0);
		send_fields(FUNC_LOOKUP, 4'd0, '1, '1, '0, '0, 1'b0, 1'b0);
		send_fields(FUNC_WRITE, 4'd1, '0, '0, '0, '0, 1'b0, 1'b1);
		send_fields(FUNC_LOOKUP, 4'd0, '0, '0, '0, '0, 1'b0, 1'b0);
		// Freeing slot 0 leaves only the listener in slot 3 for this tuple.
		send_fields(FUNC_WRITE, 4'd0, ax, pp, ar, pq, 1'b0, 1'b0);
		send_fields(FUNC_LOOKUP, 4'd0, ax, pp, ar, pq, 1'b0, 1'b0);
		send_fields(FUNC_WRITE, 4'd0, ay, pp + 16'd1, ar, pq, 1'b0, 1'b1);
		send_fields(FUNC_LOOKUP, 4'd0, ay, pp + 16'd1, ar, pq, 1'b0, 1'b0);
		send_fields(FUNC_LOOKUP, 4'd0, ax, 16'd443, ar, pq, 1'b0, 1'b0);
	endtask

	initial begin
		int gap_pct[3];
		gap_pct = '{36, 77, 0};
		tracker = new();
		addr_pool = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
		port_pool = '{16'h0, 16'hFFFF, 16'($urandom), 16'($urandom)};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();
		wait_drained();

		// Random phases with different sender gap rates; drain between them.
		for (int p = 0; p < 3; p++) begin
			repeat (RANDOM_PER_PHASE) begin
				sender_gap(gap_pct[p]);
				send_item(random_item());
			end
			wait_drained();
		end

		start <= 1'b0;
		repeat (ENTRIES_DEF + 4) @(posedge clk);

		$display("Covered %0d writes and %0d lookups: %0d exact hits,",
			tracker.writes, tracker.exact_hits + tracker.listen_hits + tracker.misses,
			tracker.exact_hits);
		$display("%0d listening hits and %0d misses; sender gap rates of 36, 77 and 0 %s",
			tracker.listen_hits, tracker.misses, "percent with full drains.");
		if (tracker.pending_results.size() != 0)
			$display("%0d predicted results never arrived", tracker.pending_results.size());
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", tracker.mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- connection_tuple_lookup.f -----
rtl/ctl_pkg.sv
rtl/ctl_cell.sv
rtl/connection_tuple_lookup.sv
tb/sv/tb.sv
